[src/pofp_pkg.sv]
// Shared constants, command codes and control structs for the plane orientation block.
package pofp_pkg;

  // Fraction bits of the quaternion components.
  localparam int unsigned QUAT_FRAC_BITS = 30;
  // Width of the scaled dividend (numerator below 2^32, shifted, plus half the divisor).
  localparam int unsigned DVD_W = 33 + QUAT_FRAC_BITS;
  // Square root steps for a 64-bit radicand, two bits a step.
  localparam int unsigned SQRT_STEPS = 32;
  // Step counter wide enough for the longest loop.
  localparam int unsigned CNT_W = $clog2(DVD_W);
  // Edge vector, product and cross product widths.
  localparam int unsigned EDGE_W = 33;
  localparam int unsigned PROD_W = 2 * EDGE_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  // Radicand and root working width.
  localparam int unsigned RT_W = 65;

  localparam logic [31:0] QUAT_ONE = 32'(64'd1 << QUAT_FRAC_BITS);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_V1_ZERO   = 2'd1,
    ST_V2_ZERO   = 2'd2,
    ST_COLLINEAR = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL,
    OP_ACC,
    OP_MAG,
    OP_NORM,
    OP_SQ,
    OP_SQACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_T,
    OP_LT_MUL,
    OP_DEN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_HALF_TURN
  } op_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic       load;
    op_e        op;
    logic [2:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic v1_zero;
    logic v2_zero;
    logic c_zero;
    logic norm_done;
    logic t_zero;
  } sts_t;

endpackage

[src/pofp_pts_if.sv]
// Input channel carrying one word of three points.
interface pofp_pts_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] p1_x;
  logic signed [31:0] p1_y;
  logic signed [31:0] p1_z;
  logic signed [31:0] p2_x;
  logic signed [31:0] p2_y;
  logic signed [31:0] p2_z;
  logic signed [31:0] p3_x;
  logic signed [31:0] p3_y;
  logic signed [31:0] p3_z;

  modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                  input ready);
  modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                output ready);
  modport mon (input valid, ready, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z);
endinterface

[src/pofp_res_if.sv]
// Output channel carrying one word of status and quaternion.
interface pofp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;

  modport source (output valid, status, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, status, quat_x, quat_y, quat_z, quat_w, output ready);
  modport mon (input valid, ready, status, quat_x, quat_y, quat_z, quat_w);
endinterface

[src/plane_orientation_from_points_top.sv]
// Top level of the plane orientation block: controller and datapath joined.
// Takes one word of three points, forms the plane normal by exact cross product and returns
// the rotation from +Z onto it as a Q2.30 quaternion with a status code; on any failure the
// previously held quaternion is returned unchanged. One word is in flight at a time: ready is
// high only while idle and the result has been taken. A good triple runs three 63-step restoring
// divisions and two 32-step square roots, plus the one-bit-a-cycle normalising shift of the
// cross product.
module plane_orientation_from_points_top
  import pofp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  pofp_pts_if.sink   pts_i,
  pofp_res_if.source res_o
);

  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] status;

  pofp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pts_i.valid),
    .in_ready_o  (pts_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_o    (status),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pofp_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .p1_x_i   (pts_i.p1_x),
    .p1_y_i   (pts_i.p1_y),
    .p1_z_i   (pts_i.p1_z),
    .p2_x_i   (pts_i.p2_x),
    .p2_y_i   (pts_i.p2_y),
    .p2_z_i   (pts_i.p2_z),
    .p3_x_i   (pts_i.p3_x),
    .p3_y_i   (pts_i.p3_y),
    .p3_z_i   (pts_i.p3_z),
    .quat_x_o (res_o.quat_x),
    .quat_y_o (res_o.quat_y),
    .quat_z_o (res_o.quat_z),
    .quat_w_o (res_o.quat_w)
  );

  assign res_o.status = status;

endmodule

[src/pofp_ctrl.sv]
// Controller state machine sequencing the datapath for one word at a time.
module pofp_ctrl
  import pofp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_EDGE, S_CROSS, S_MAG, S_ZCHK, S_NORM, S_SQ, S_RT_INIT, S_RT, S_T,
    S_TCHK, S_HALF, S_LT, S_RT2_INIT, S_RT2, S_DEN, S_DV_INIT, S_DV, S_DV_STORE, S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       k_q;
  status_e          status_q;
  logic             out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  // Command decode from the current state and step counter.
  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    cmd_o.load = in_valid_i && (state_q == S_IDLE);
    case (state_q)
      S_CROSS: begin
        cmd_o.op  = cnt_q[0] ? OP_ACC : OP_MUL;
        cmd_o.idx = cnt_q[3:1];
      end
      S_MAG:      cmd_o.op = OP_MAG;
      S_NORM:     cmd_o.op = OP_NORM;
      S_SQ: begin
        cmd_o.op  = cnt_q[0] ? OP_SQACC : OP_SQ;
        cmd_o.idx = {1'b0, cnt_q[2:1]};
      end
      S_RT_INIT:  cmd_o.op = OP_SQRT_INIT;
      S_RT:       cmd_o.op = OP_SQRT_STEP;
      S_T:        cmd_o.op = OP_T;
      S_HALF:     cmd_o.op = OP_HALF_TURN;
      S_LT:       cmd_o.op = OP_LT_MUL;
      S_RT2_INIT: begin
        cmd_o.op  = OP_SQRT_INIT;
        cmd_o.idx = 3'd1;
      end
      S_RT2:      cmd_o.op = OP_SQRT_STEP;
      S_DEN:      cmd_o.op = OP_DEN;
      S_DV_INIT: begin
        cmd_o.op  = OP_DIV_INIT;
        cmd_o.idx = {1'b0, k_q};
      end
      S_DV:       cmd_o.op = OP_DIV_STEP;
      S_DV_STORE: begin
        cmd_o.op  = OP_DIV_STORE;
        cmd_o.idx = {1'b0, k_q};
      end
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  // State, counters and the registered output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EDGE;
        end
        S_EDGE: begin
          cnt_q <= '0;
          if (sts_i.v1_zero) begin
            status_q    <= ST_V1_ZERO;
            out_valid_q <= 1'b1;
            state_q     <= S_DONE;
          end else if (sts_i.v2_zero) begin
            status_q    <= ST_V2_ZERO;
            out_valid_q <= 1'b1;
            state_q     <= S_DONE;
          end else begin
            state_q <= S_CROSS;
          end
        end
        S_CROSS: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(11)) state_q <= S_MAG;
        end
        S_MAG: state_q <= S_ZCHK;
        S_ZCHK: begin
          if (sts_i.c_zero) begin
            status_q    <= ST_COLLINEAR;
            out_valid_q <= 1'b1;
            state_q     <= S_DONE;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          cnt_q <= '0;
          if (sts_i.norm_done) state_q <= S_SQ;
        end
        S_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(5)) state_q <= S_RT_INIT;
        end
        S_RT_INIT: begin
          cnt_q   <= '0;
          state_q <= S_RT;
        end
        S_RT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_q <= S_T;
        end
        S_T: state_q <= S_TCHK;
        S_TCHK: state_q <= sts_i.t_zero ? S_HALF : S_LT;
        S_HALF: begin
          status_q    <= ST_OK;
          out_valid_q <= 1'b1;
          state_q     <= S_DONE;
        end
        S_LT: state_q <= S_RT2_INIT;
        S_RT2_INIT: begin
          cnt_q   <= '0;
          state_q <= S_RT2;
        end
        S_RT2: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_q <= S_DEN;
        end
        S_DEN: begin
          k_q     <= '0;
          state_q <= S_DV_INIT;
        end
        S_DV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DV;
        end
        S_DV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DVD_W - 1)) state_q <= S_DV_STORE;
        end
        S_DV_STORE: begin
          if (k_q == 2'd2) begin
            status_q    <= ST_OK;
            out_valid_q <= 1'b1;
            state_q     <= S_DONE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_DV_INIT;
          end
        end
        S_DONE: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[src/pofp_datapath.sv]
// Datapath: edge vectors, cross product, scaling, square roots, divider and held quaternion.
module pofp_datapath
  import pofp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic signed [31:0] p1_x_i,
  input  logic signed [31:0] p1_y_i,
  input  logic signed [31:0] p1_z_i,
  input  logic signed [31:0] p2_x_i,
  input  logic signed [31:0] p2_y_i,
  input  logic signed [31:0] p2_z_i,
  input  logic signed [31:0] p3_x_i,
  input  logic signed [31:0] p3_y_i,
  input  logic signed [31:0] p3_z_i,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o,
  output logic signed [31:0] quat_w_o
);

  logic signed [EDGE_W-1:0]  d1_q [3];
  logic signed [EDGE_W-1:0]  d2_q [3];
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [CROSS_W-1:0] c_q [3];
  logic [CROSS_W-1:0]        m_q [3];
  logic [2:0]                neg_q;
  logic [59:0]               sq_q;
  logic [61:0]               acc_q;
  logic [RT_W-1:0]           rad_q, res_q, bit_q;
  logic [30:0]               l_q;
  logic [31:0]               t_q;
  logic [62:0]               lt_q;
  logic [31:0]               den_q;
  logic [DVD_W-1:0]          quo_q;
  logic [31:0]               rem_q;
  logic [31:0]               held_q [4];

  logic signed [EDGE_W-1:0]  mul_a, mul_b;
  logic [CROSS_W-1:0]        or_v;
  logic [29:0]               a_v [3];
  logic [29:0]               sq_sel;
  logic [RT_W-1:0]           rt_sum;
  logic [32:0]               rem_sh;
  logic                      rem_ge;
  logic [31:0]               div_num;
  logic [31:0]               quo_sat;
  logic                      quo_neg;
  logic [1:0]                ci;

  assign a_v[0] = m_q[0][29:0];
  assign a_v[1] = m_q[1][29:0];
  assign a_v[2] = m_q[2][29:0];
  assign or_v   = m_q[0] | m_q[1] | m_q[2];
  assign ci     = 2'(cmd_i.idx >> 1);

  // Status back to the controller.
  assign sts_o.v1_zero   = (d1_q[0] == '0) && (d1_q[1] == '0) && (d1_q[2] == '0);
  assign sts_o.v2_zero   = (d2_q[0] == '0) && (d2_q[1] == '0) && (d2_q[2] == '0);
  assign sts_o.c_zero    = (or_v == '0);
  assign sts_o.norm_done = (or_v[CROSS_W-1:30] == '0) && or_v[29];
  assign sts_o.t_zero    = (t_q == '0);

  // Operand selection for the six cross product terms.
  always_comb begin
    case (cmd_i.idx)
      3'd0:    begin mul_a = d1_q[1]; mul_b = d2_q[2]; end
      3'd1:    begin mul_a = d1_q[2]; mul_b = d2_q[1]; end
      3'd2:    begin mul_a = d1_q[2]; mul_b = d2_q[0]; end
      3'd3:    begin mul_a = d1_q[0]; mul_b = d2_q[2]; end
      3'd4:    begin mul_a = d1_q[0]; mul_b = d2_q[1]; end
      3'd5:    begin mul_a = d1_q[1]; mul_b = d2_q[0]; end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end

  // Component picked for squaring and numerator picked for division.
  always_comb begin
    case (cmd_i.idx)
      3'd0:    sq_sel = a_v[0];
      3'd1:    sq_sel = a_v[1];
      3'd2:    sq_sel = a_v[2];
      default: sq_sel = '0;
    endcase
    case (cmd_i.idx)
      3'd0:    div_num = {2'b00, a_v[1]};
      3'd1:    div_num = {2'b00, a_v[0]};
      default: div_num = t_q;
    endcase
  end

  // One square root step and one restoring division step.
  assign rt_sum = res_q + bit_q;
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  // Saturation and sign of a finished quotient.
  always_comb begin
    quo_sat = (quo_q > DVD_W'(QUAT_ONE)) ? QUAT_ONE : quo_q[31:0];
    case (cmd_i.idx)
      3'd0:    quo_neg = !neg_q[1];
      3'd1:    quo_neg = neg_q[0];
      default: quo_neg = 1'b0;
    endcase
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d1_q[0] <= EDGE_W'(p2_x_i) - EDGE_W'(p1_x_i);
      d1_q[1] <= EDGE_W'(p2_y_i) - EDGE_W'(p1_y_i);
      d1_q[2] <= EDGE_W'(p2_z_i) - EDGE_W'(p1_z_i);
      d2_q[0] <= EDGE_W'(p3_x_i) - EDGE_W'(p1_x_i);
      d2_q[1] <= EDGE_W'(p3_y_i) - EDGE_W'(p1_y_i);
      d2_q[2] <= EDGE_W'(p3_z_i) - EDGE_W'(p1_z_i);
    end
    case (cmd_i.op)
      OP_MUL: prod_q <= mul_a * mul_b;
      OP_ACC: begin
        if (!cmd_i.idx[0]) c_q[ci] <= CROSS_W'(prod_q);
        else               c_q[ci] <= c_q[ci] - CROSS_W'(prod_q);
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= c_q[i][CROSS_W-1] ? CROSS_W'(-c_q[i]) : CROSS_W'(c_q[i]);
          neg_q[i] <= c_q[i][CROSS_W-1];
        end
      end
      OP_NORM: begin
        if (or_v[CROSS_W-1:30] != '0) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (!or_v[29]) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
      end
      OP_SQ: sq_q <= sq_sel * sq_sel;
      OP_SQACC: begin
        if (cmd_i.idx == 3'd0) acc_q <= 62'(sq_q);
        else                   acc_q <= acc_q + 62'(sq_q);
      end
      OP_SQRT_INIT: begin
        rad_q <= (cmd_i.idx == 3'd0) ? RT_W'(acc_q) : RT_W'({lt_q, 1'b0});
        res_q <= '0;
        bit_q <= RT_W'(65'd1 << 62);
      end
      OP_SQRT_STEP: begin
        if (rad_q >= rt_sum) begin
          rad_q <= rad_q - rt_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_T: begin
        l_q <= res_q[30:0];
        t_q <= neg_q[2] ? ({1'b0, res_q[30:0]} - {2'b00, a_v[2]})
                        : ({1'b0, res_q[30:0]} + {2'b00, a_v[2]});
      end
      OP_LT_MUL: lt_q <= l_q * t_q;
      OP_DEN:    den_q <= res_q[31:0];
      OP_DIV_INIT: begin
        quo_q <= (DVD_W'(div_num) << QUAT_FRAC_BITS) + DVD_W'(den_q >> 1);
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
        quo_q <= {quo_q[DVD_W-2:0], rem_ge};
      end
      default: ;
    endcase
  end

  // Held quaternion {x, y, z, w}; replaced only on success.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[0] <= '0;
      held_q[1] <= '0;
      held_q[2] <= '0;
      held_q[3] <= QUAT_ONE;
    end else begin
      case (cmd_i.op)
        OP_HALF_TURN: begin
          held_q[0] <= QUAT_ONE;
          held_q[1] <= '0;
          held_q[2] <= '0;
          held_q[3] <= '0;
        end
        OP_DIV_STORE: begin
          case (cmd_i.idx)
            3'd0:    held_q[0] <= quo_neg ? -quo_sat : quo_sat;
            3'd1:    held_q[1] <= quo_neg ? -quo_sat : quo_sat;
            default: begin
              held_q[2] <= '0;
              held_q[3] <= quo_sat;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign quat_x_o = held_q[0];
  assign quat_y_o = held_q[1];
  assign quat_z_o = held_q[2];
  assign quat_w_o = held_q[3];

endmodule

[src/pofp_checker.sv]
// Port-level checks on the plane orientation block and their binding to the top level.
module pofp_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pts_valid_i,
  input logic        pts_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  res_status_i,
  input logic [31:0] quat_x_i,
  input logic [31:0] quat_y_i,
  input logic [31:0] quat_z_i,
  input logic [31:0] quat_w_i
);

  // Only one word is in flight: no new word is taken while a result waits.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pts_ready_i && res_valid_i))
    else $error("input ready while a result is pending");

  // Taking a word closes the input for at least the next cycle.
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pts_valid_i && pts_ready_i) |=> !pts_ready_i)
    else $error("input still ready after a word was taken");

  // A stalled result holds its status and the x, y and w parts of its quaternion.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(quat_x_i)
      && $stable(quat_y_i) && $stable(quat_w_i) && $stable(res_status_i)))
    else $error("stalled result changed");

  // While a result is valid, the rotation has no z part and its w part is not negative.
  a_quat_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (quat_z_i == '0) && !quat_w_i[31])
    else $error("quaternion has a z part or a negative w part");

endmodule

bind plane_orientation_from_points_top pofp_port_checks u_pofp_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pts_valid_i  (pts_i.valid),
  .pts_ready_i  (pts_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status),
  .quat_x_i     (res_o.quat_x),
  .quat_y_i     (res_o.quat_y),
  .quat_z_i     (res_o.quat_z),
  .quat_w_i     (res_o.quat_w)
);
